### hw/rtl/vna_pkg.sv
// shared types and constants for the vertex normal accumulator
package vna_pkg;

   localparam int MaxVertices = 1024;
   localparam int SumWidth    = 48;
   localparam int IdxWidth    = $clog2(MaxVertices);
   localparam int MagWidth    = 31;
   localparam int SqWidth     = 2 * MagWidth + 2;
   localparam int RootWidth   = SqWidth / 2;
   localparam int QuotWidth   = 16;
   localparam int NumWidth    = MagWidth + 14 + 1;
   localparam logic [15:0] Q14One = 16'd16384;

   typedef enum logic [1:0] {
      ACT_LOAD = 2'd0,
      ACT_TRI  = 2'd1,
      ACT_READ = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [9:0]         vertex;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [9:0]         corner_a;
      logic [9:0]         corner_b;
      logic [9:0]         corner_c;
   } req_type;

   typedef struct packed {
      logic [9:0]         out_vertex;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               degenerate;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOAD,
      ST_TRI_RD_A,
      ST_TRI_RD_B,
      ST_TRI_RD_C,
      ST_TRI_EDGE,
      ST_TRI_MUL,
      ST_TRI_SUM,
      ST_TRI_ACC_A,
      ST_TRI_WR_A,
      ST_TRI_ACC_B,
      ST_TRI_WR_B,
      ST_TRI_ACC_C,
      ST_TRI_WR_C,
      ST_RD_FETCH,
      ST_RD_MAG,
      ST_RD_SHIFT,
      ST_RD_SQ,
      ST_RD_SQSUM,
      ST_RD_SQRT,
      ST_RD_DIV,
      ST_RD_OUT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       load_wr;
      logic       pos_rd;
      logic [1:0] pos_sel;
      logic       edge_en;
      logic       mul_en;
      logic       cross_en;
      logic       sum_rd;
      logic [1:0] sum_sel;
      logic       sum_wr;
      logic       mag_en;
      logic       shift_en;
      logic       sq_en;
      logic       sqrt_start;
      logic       sqrt_step;
      logic       div_start;
      logic       div_step;
      logic       rsp_fire;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic sqrt_done;
      logic div_done;
   } stat_type;

   function automatic logic [SumWidth-1:0] sat_add(input logic [SumWidth-1:0] a,
                                                   input logic [SumWidth-1:0] b);
      logic [SumWidth-1:0] s;
      s = a + b;
      if (a[SumWidth-1] == b[SumWidth-1] && s[SumWidth-1] != a[SumWidth-1])
         s = a[SumWidth-1] ? {1'b1, {(SumWidth-1){1'b0}}} : {1'b0, {(SumWidth-1){1'b1}}};
      return s;
   endfunction

endpackage

### hw/rtl/vna_ctrl.sv
// controller state machine for the vertex normal accumulator
module vna_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  vna_pkg::req_type  req,
   input  vna_pkg::stat_type stat,
   output logic              busy,
   output vna_pkg::cmd_type  cmd
);

   vna_pkg::state_type state_ff, state_in;
   logic idx_ok;

   assign idx_ok = (32'(req.corner_a) < vna_pkg::MaxVertices) &&
                   (32'(req.corner_b) < vna_pkg::MaxVertices) &&
                   (32'(req.corner_c) < vna_pkg::MaxVertices);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= vna_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != vna_pkg::ST_IDLE);
      case (state_ff)
         vna_pkg::ST_IDLE: begin
            if (start) begin
               case (vna_pkg::action_type'(req.action))
                  vna_pkg::ACT_LOAD: state_in = vna_pkg::ST_LOAD;
                  vna_pkg::ACT_TRI: if (idx_ok) state_in = vna_pkg::ST_TRI_RD_A;
                  vna_pkg::ACT_READ: state_in = vna_pkg::ST_RD_FETCH;
                  default: state_in = vna_pkg::ST_IDLE;
               endcase
            end
         end
         vna_pkg::ST_LOAD: begin
            cmd.load_wr = 1'b1;
            state_in = vna_pkg::ST_IDLE;
         end
         vna_pkg::ST_TRI_RD_A: begin
            cmd.pos_rd = 1'b1; cmd.pos_sel = 2'd0;
            state_in = vna_pkg::ST_TRI_RD_B;
         end
         vna_pkg::ST_TRI_RD_B: begin
            cmd.pos_rd = 1'b1; cmd.pos_sel = 2'd1;
            state_in = vna_pkg::ST_TRI_RD_C;
         end
         vna_pkg::ST_TRI_RD_C: begin
            cmd.pos_rd = 1'b1; cmd.pos_sel = 2'd2;
            state_in = vna_pkg::ST_TRI_EDGE;
         end
         vna_pkg::ST_TRI_EDGE: begin
            cmd.edge_en = 1'b1;
            state_in = vna_pkg::ST_TRI_MUL;
         end
         vna_pkg::ST_TRI_MUL: begin
            cmd.mul_en = 1'b1;
            state_in = vna_pkg::ST_TRI_SUM;
         end
         vna_pkg::ST_TRI_SUM: begin
            cmd.cross_en = 1'b1;
            cmd.sum_rd = 1'b1; cmd.sum_sel = 2'd0;
            state_in = vna_pkg::ST_TRI_ACC_A;
         end
         vna_pkg::ST_TRI_ACC_A: state_in = vna_pkg::ST_TRI_WR_A;
         vna_pkg::ST_TRI_WR_A: begin
            cmd.sum_wr = 1'b1; cmd.sum_sel = 2'd0;
            state_in = vna_pkg::ST_TRI_ACC_B;
         end
         vna_pkg::ST_TRI_ACC_B: begin
            cmd.sum_rd = 1'b1; cmd.sum_sel = 2'd1;
            state_in = vna_pkg::ST_TRI_WR_B;
         end
         vna_pkg::ST_TRI_WR_B: begin
            cmd.sum_wr = 1'b1; cmd.sum_sel = 2'd1;
            state_in = vna_pkg::ST_TRI_ACC_C;
         end
         vna_pkg::ST_TRI_ACC_C: begin
            cmd.sum_rd = 1'b1; cmd.sum_sel = 2'd2;
            state_in = vna_pkg::ST_TRI_WR_C;
         end
         vna_pkg::ST_TRI_WR_C: begin
            cmd.sum_wr = 1'b1; cmd.sum_sel = 2'd2;
            state_in = vna_pkg::ST_IDLE;
         end
         vna_pkg::ST_RD_FETCH: begin
            cmd.sum_rd = 1'b1; cmd.sum_sel = 2'd3;
            state_in = vna_pkg::ST_RD_MAG;
         end
         vna_pkg::ST_RD_MAG: begin
            cmd.mag_en = 1'b1;
            state_in = vna_pkg::ST_RD_SHIFT;
         end
         vna_pkg::ST_RD_SHIFT: begin
            cmd.shift_en = 1'b1;
            state_in = vna_pkg::ST_RD_SQ;
         end
         vna_pkg::ST_RD_SQ: begin
            cmd.sq_en = 1'b1;
            state_in = vna_pkg::ST_RD_SQSUM;
         end
         vna_pkg::ST_RD_SQSUM: begin
            // root starts from the sum of the squares
            cmd.sqrt_start = 1'b1;
            state_in = vna_pkg::ST_RD_SQRT;
         end
         vna_pkg::ST_RD_SQRT: begin
            if (!stat.sqrt_done) cmd.sqrt_step = 1'b1;
            else begin
               cmd.div_start = 1'b1;
               state_in = vna_pkg::ST_RD_DIV;
            end
         end
         vna_pkg::ST_RD_DIV: begin
            if (!stat.div_done) cmd.div_step = 1'b1;
            else state_in = vna_pkg::ST_RD_OUT;
         end
         vna_pkg::ST_RD_OUT: begin
            cmd.rsp_fire = 1'b1;
            state_in = vna_pkg::ST_IDLE;
         end
         default: state_in = vna_pkg::ST_IDLE;
      endcase
   end

`ifndef ASSERT_OFF
   a_idle_not_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vna_pkg::ST_IDLE) |-> !busy)
      else $error("idle but busy");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.sum_wr && cmd.load_wr))
      else $error("two writes at once");
   a_rsp_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_fire |=> (state_ff == vna_pkg::ST_IDLE))
      else $error("result not followed by idle");
`endif

endmodule

### hw/rtl/vna_datapath.sv
// datapath: vertex stores, cross product, accumulate and normalize
module vna_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  vna_pkg::req_type  req,
   input  vna_pkg::cmd_type  cmd,
   output vna_pkg::stat_type stat,
   output logic              rsp_valid,
   output vna_pkg::rsp_type  rsp
);

   localparam int SW = vna_pkg::SumWidth;
   localparam int IW = vna_pkg::IdxWidth;
   localparam int MW = vna_pkg::MagWidth;
   localparam int QW = vna_pkg::SqWidth;
   localparam int RW = vna_pkg::RootWidth;
   localparam int NW = vna_pkg::NumWidth;
   localparam int DQ = vna_pkg::QuotWidth;

   logic [47:0]   pos_mem [vna_pkg::MaxVertices];
   logic [SW-1:0] sx_mem  [vna_pkg::MaxVertices];
   logic [SW-1:0] sy_mem  [vna_pkg::MaxVertices];
   logic [SW-1:0] sz_mem  [vna_pkg::MaxVertices];

   vna_pkg::req_type req_ff;
   logic          idx_ok;
   logic [IW-1:0] pos_addr, sum_addr;
   logic [47:0]   pos_rd_ff;
   logic [47:0]   pa_ff, pb_ff;
   logic signed [16:0] e1_ff [3];
   logic signed [16:0] e2_ff [3];
   logic signed [33:0] pr_ff [6];
   logic [SW-1:0] n_ff [3];
   logic [SW-1:0] sx_rd_ff, sy_rd_ff, sz_rd_ff;
   logic [SW-1:0] m_ff [3];
   logic          neg_ff [3];
   logic          zero_ff;
   logic [MW-1:0] ms_ff [3];
   logic [QW-1:0] sq_ff [3];
   logic [QW-1:0] rem_ff, root_ff, bit_ff;
   logic          sq_done_ff;
   logic [RW-1:0] len_ff;
   logic [1:0]    dcomp_ff;
   logic [5:0]    dbit_ff;
   logic [NW-1:0] drem_ff;
   logic [NW-1:0] dnum_ff;
   logic [DQ-1:0] q_ff [3];
   logic          div_done_ff;
   logic          rsp_valid_ff;
   vna_pkg::rsp_type rsp_ff;

   assign idx_ok = 32'(req_ff.vertex) < vna_pkg::MaxVertices;

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req;
   end

   always_comb begin
      case (cmd.pos_sel)
         2'd0:    pos_addr = req_ff.corner_a[IW-1:0];
         2'd1:    pos_addr = req_ff.corner_b[IW-1:0];
         default: pos_addr = req_ff.corner_c[IW-1:0];
      endcase
      case (cmd.sum_sel)
         2'd0:    sum_addr = req_ff.corner_a[IW-1:0];
         2'd1:    sum_addr = req_ff.corner_b[IW-1:0];
         2'd2:    sum_addr = req_ff.corner_c[IW-1:0];
         default: sum_addr = req_ff.vertex[IW-1:0];
      endcase
   end

   // position store
   always_ff @(posedge clock) begin
      if (cmd.load_wr && idx_ok)
         pos_mem[req_ff.vertex[IW-1:0]] <= {req_ff.pos_x, req_ff.pos_y, req_ff.pos_z};
      if (cmd.pos_rd) pos_rd_ff <= pos_mem[pos_addr];
   end

   // sum stores: one read and one write port each
   always_ff @(posedge clock) begin
      if (cmd.load_wr && idx_ok) begin
         sx_mem[req_ff.vertex[IW-1:0]] <= '0;
         sy_mem[req_ff.vertex[IW-1:0]] <= '0;
         sz_mem[req_ff.vertex[IW-1:0]] <= '0;
      end else if (cmd.sum_wr) begin
         sx_mem[sum_addr] <= vna_pkg::sat_add(sx_rd_ff, n_ff[0]);
         sy_mem[sum_addr] <= vna_pkg::sat_add(sy_rd_ff, n_ff[1]);
         sz_mem[sum_addr] <= vna_pkg::sat_add(sz_rd_ff, n_ff[2]);
      end
      if (cmd.sum_rd) begin
         sx_rd_ff <= sx_mem[sum_addr];
         sy_rd_ff <= sy_mem[sum_addr];
         sz_rd_ff <= sz_mem[sum_addr];
      end
   end

   // corner positions arrive one per cycle after each read
   always_ff @(posedge clock) begin
      if (cmd.pos_sel == 2'd1 && cmd.pos_rd) pa_ff <= pos_rd_ff;
      if (cmd.pos_sel == 2'd2 && cmd.pos_rd) pb_ff <= pos_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.edge_en) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= 17'(signed'(pb_ff[47-16*i -: 16])) -
                        17'(signed'(pa_ff[47-16*i -: 16]));
            e2_ff[i] <= 17'(signed'(pos_rd_ff[47-16*i -: 16])) -
                        17'(signed'(pa_ff[47-16*i -: 16]));
         end
      end
      if (cmd.mul_en) begin
         pr_ff[0] <= e1_ff[1] * e2_ff[2];
         pr_ff[1] <= e1_ff[2] * e2_ff[1];
         pr_ff[2] <= e1_ff[2] * e2_ff[0];
         pr_ff[3] <= e1_ff[0] * e2_ff[2];
         pr_ff[4] <= e1_ff[0] * e2_ff[1];
         pr_ff[5] <= e1_ff[1] * e2_ff[0];
      end
      if (cmd.cross_en) begin
         for (int i = 0; i < 3; i++)
            n_ff[i] <= SW'($signed(35'(pr_ff[2*i]) - 35'(pr_ff[2*i+1])));
      end
   end

   // magnitudes and range reduction to 31 bits
   always_ff @(posedge clock) begin
      logic [SW-1:0] v [3];
      logic [SW-1:0] big;
      int unsigned   sh;
      if (cmd.mag_en) begin
         v[0] = sx_rd_ff; v[1] = sy_rd_ff; v[2] = sz_rd_ff;
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= v[i][SW-1];
            m_ff[i]   <= v[i][SW-1] ? -v[i] : v[i];
         end
      end
      if (cmd.shift_en) begin
         big = m_ff[0] | m_ff[1] | m_ff[2];
         sh = 0;
         for (int b = MW; b < SW; b++)
            if (big[b]) sh = b - MW + 1;
         zero_ff <= (big == '0) || !idx_ok;
         for (int i = 0; i < 3; i++) ms_ff[i] <= MW'(m_ff[i] >> sh);
      end
   end

   // squares, then bitwise integer square root of their sum
   always_ff @(posedge clock) begin
      if (cmd.sq_en)
         for (int i = 0; i < 3; i++) sq_ff[i] <= QW'(ms_ff[i]) * QW'(ms_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (reset) sq_done_ff <= 1'b0;
      else if (cmd.sqrt_start) begin
         rem_ff     <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         root_ff    <= '0;
         bit_ff     <= {2'b01, {(QW-2){1'b0}}};
         sq_done_ff <= 1'b0;
      end else if (cmd.sqrt_step) begin
         if (rem_ff >= root_ff + bit_ff) begin
            rem_ff  <= rem_ff - (root_ff + bit_ff);
            root_ff <= (root_ff >> 1) + bit_ff;
         end else root_ff <= root_ff >> 1;
         bit_ff <= bit_ff >> 2;
         if (bit_ff[1:0] != 2'b00) sq_done_ff <= 1'b1;
      end
   end
   assign stat.sqrt_done = sq_done_ff;

   // restoring divider, one quotient bit per cycle, components in turn
   always_ff @(posedge clock) begin
      logic [NW:0] trial;
      if (reset) div_done_ff <= 1'b0;
      else if (cmd.div_start) begin
         len_ff      <= RW'(root_ff);
         dcomp_ff    <= 2'd0;
         dbit_ff     <= 6'(NW);
         drem_ff     <= '0;
         dnum_ff     <= (NW'(ms_ff[0]) << 14) + NW'(root_ff[RW-1:1]);
         div_done_ff <= (root_ff == '0);
      end else if (cmd.div_step) begin
         trial = {drem_ff, dnum_ff[NW-1]};
         if (trial >= (NW+1)'(len_ff)) drem_ff <= NW'(trial - (NW+1)'(len_ff));
         else drem_ff <= NW'(trial);
         dnum_ff <= {dnum_ff[NW-2:0], trial >= (NW+1)'(len_ff)};
         if (dbit_ff == 6'd1) begin
            q_ff[dcomp_ff] <= DQ'({dnum_ff[NW-2:0], trial >= (NW+1)'(len_ff)});
            if (dcomp_ff == 2'd2) div_done_ff <= 1'b1;
            else begin
               dcomp_ff <= dcomp_ff + 2'd1;
               dbit_ff  <= 6'(NW);
               drem_ff  <= '0;
               dnum_ff  <= (NW'(ms_ff[dcomp_ff + 2'd1]) << 14) + NW'(len_ff >> 1);
            end
         end else dbit_ff <= dbit_ff - 6'd1;
      end
   end
   assign stat.div_done = div_done_ff;

   always_ff @(posedge clock) begin
      logic [DQ-1:0] q;
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= cmd.rsp_fire;
      if (cmd.rsp_fire) begin
         rsp_ff.out_vertex <= req_ff.vertex;
         if (zero_ff || len_ff == '0) begin
            rsp_ff.normal_x   <= '0;
            rsp_ff.normal_y   <= vna_pkg::Q14One;
            rsp_ff.normal_z   <= '0;
            rsp_ff.degenerate <= 1'b1;
         end else begin
            q = (q_ff[0] > vna_pkg::Q14One) ? vna_pkg::Q14One : q_ff[0];
            rsp_ff.normal_x <= neg_ff[0] ? -q : q;
            q = (q_ff[1] > vna_pkg::Q14One) ? vna_pkg::Q14One : q_ff[1];
            rsp_ff.normal_y <= neg_ff[1] ? -q : q;
            q = (q_ff[2] > vna_pkg::Q14One) ? vna_pkg::Q14One : q_ff[2];
            rsp_ff.normal_z <= neg_ff[2] ? -q : q;
            rsp_ff.degenerate <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef ASSERT_OFF
   a_div_after_root: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> sq_done_ff)
      else $error("divide started before root done");
   a_norm_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.normal_y == vna_pkg::Q14One || !rsp_ff.degenerate))
      else $error("degenerate result without up normal");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held two cycles");
`endif

endmodule

### hw/rtl/vertex_normal_accumulator.sv
// top level of the vertex normal accumulator
//   channel   ports                       transfer
//   request   start, busy, req_item       start high and busy low at clock edge
//   result    rsp_strobe, rsp_item        one cycle per strobe, no backpressure
// a triangle runs three position reads, edge, multiply and three sum read-modify-writes;
// the time of a read is set by the bitwise square root and the one-bit-per-cycle divider
// shared by all components; the divide is skipped for an all-zero sum.
// reset is synchronous and clears control only; stores are undefined until loaded.
// the result strobe is not held: the receiver takes it in its one cycle.
module vertex_normal_accumulator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  vna_pkg::req_type req_item,
   output logic             rsp_strobe,
   output vna_pkg::rsp_type rsp_item
);

   vna_pkg::cmd_type  cmd;
   vna_pkg::stat_type stat;
   logic              accept;

   assign accept = start && !busy;

   vna_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .req   (req_item),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   vna_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_strobe),
      .rsp       (rsp_item)
   );

endmodule
